@@ sv/mer_pkg.sv @@
// Shared types and constants of the midpoint ellipse rasterizer.
`timescale 1ns / 1ps
package mer_pkg;

  localparam int CENTER_W  = 12;
  localparam int RADIUS_W  = 11;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_W     = 14;
  localparam int POS_X_W   = 12;
  localparam int POS_Y_W   = 13;
  localparam int WIDE_W    = 48;
  localparam int SQ_W      = 2 * RADIUS_W;
  localparam int MUL_W     = 26;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int ACC_W     = PROD_W + 2;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_Y = 2'd3;

  localparam logic [1:0] QUAD_FIRST = 2'd0;
  localparam logic [1:0] QUAD_LAST  = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RX2,
    ST_RY2,
    ST_RXRY,
    ST_INIT,
    ST_CHECK,
    ST_TX,
    ST_TY,
    ST_TA,
    ST_TB,
    ST_TC,
    ST_TD,
    ST_TEST,
    ST_MOVE,
    ST_TERM,
    ST_ACC,
    ST_EMIT
  } state_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_TAKE,
    OP_SQ_RX,
    OP_SQ_RY,
    OP_RX2_RY,
    OP_INIT,
    OP_SQ_TX,
    OP_SQ_TY,
    OP_MUL_A,
    OP_MUL_B,
    OP_MUL_C,
    OP_SWITCH,
    OP_FINISH,
    OP_MOVE,
    OP_TERM,
    OP_ACC,
    OP_LOAD_PT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] quad;
  } dp_cmd_t;

  typedef struct packed {
    logic finished;
    logic switch_req;
    logic y_neg;
  } dp_sts_t;

endpackage

@@ sv/mer_ctrl.sv @@
// Sequencing state machine of the midpoint ellipse rasterizer.
`timescale 1ns / 1ps
module mer_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  mer_pkg::dp_sts_t sts,
  output mer_pkg::dp_cmd_t cmd
);

  mer_pkg::state_t state_r, state_nxt;
  logic [1:0]      quad_r, quad_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mer_pkg::ST_IDLE;
      quad_r  <= mer_pkg::QUAD_FIRST;
    end else begin
      state_r <= state_nxt;
      quad_r  <= quad_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mer_pkg::ST_IDLE:  if (in_valid) state_nxt = mer_pkg::ST_RX2;
      mer_pkg::ST_RX2:   state_nxt = mer_pkg::ST_RY2;
      mer_pkg::ST_RY2:   state_nxt = mer_pkg::ST_RXRY;
      mer_pkg::ST_RXRY:  state_nxt = mer_pkg::ST_INIT;
      mer_pkg::ST_INIT:  state_nxt = mer_pkg::ST_CHECK;
      mer_pkg::ST_CHECK: begin
        if (sts.finished)        state_nxt = mer_pkg::ST_IDLE;
        else if (sts.switch_req) state_nxt = mer_pkg::ST_TX;
        else                     state_nxt = mer_pkg::ST_TEST;
      end
      mer_pkg::ST_TX:    state_nxt = mer_pkg::ST_TY;
      mer_pkg::ST_TY:    state_nxt = mer_pkg::ST_TA;
      mer_pkg::ST_TA:    state_nxt = mer_pkg::ST_TB;
      mer_pkg::ST_TB:    state_nxt = mer_pkg::ST_TC;
      mer_pkg::ST_TC:    state_nxt = mer_pkg::ST_TD;
      mer_pkg::ST_TD:    state_nxt = mer_pkg::ST_TEST;
      mer_pkg::ST_TEST:  state_nxt = sts.y_neg ? mer_pkg::ST_IDLE : mer_pkg::ST_MOVE;
      mer_pkg::ST_MOVE:  state_nxt = mer_pkg::ST_TERM;
      mer_pkg::ST_TERM:  state_nxt = mer_pkg::ST_ACC;
      mer_pkg::ST_ACC:   state_nxt = mer_pkg::ST_EMIT;
      mer_pkg::ST_EMIT: begin
        if (out_ready && quad_r == mer_pkg::QUAD_LAST) state_nxt = mer_pkg::ST_IDLE;
      end
      default:           state_nxt = mer_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    quad_nxt = quad_r;
    case (state_r)
      mer_pkg::ST_ACC:  quad_nxt = mer_pkg::QUAD_FIRST;
      mer_pkg::ST_EMIT: begin
        if (out_ready && quad_r != mer_pkg::QUAD_LAST) quad_nxt = quad_r + 2'd1;
      end
      default:          quad_nxt = quad_r;
    endcase
  end

  always_comb begin
    cmd.op    = mer_pkg::OP_NOP;
    cmd.quad  = quad_nxt;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      mer_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = mer_pkg::OP_TAKE;
      end
      mer_pkg::ST_RX2:  cmd.op = mer_pkg::OP_SQ_RX;
      mer_pkg::ST_RY2:  cmd.op = mer_pkg::OP_SQ_RY;
      mer_pkg::ST_RXRY: cmd.op = mer_pkg::OP_RX2_RY;
      mer_pkg::ST_INIT: cmd.op = mer_pkg::OP_INIT;
      mer_pkg::ST_TX:   cmd.op = mer_pkg::OP_SQ_TX;
      mer_pkg::ST_TY:   cmd.op = mer_pkg::OP_SQ_TY;
      mer_pkg::ST_TA:   cmd.op = mer_pkg::OP_MUL_A;
      mer_pkg::ST_TB:   cmd.op = mer_pkg::OP_MUL_B;
      mer_pkg::ST_TC:   cmd.op = mer_pkg::OP_MUL_C;
      mer_pkg::ST_TD:   cmd.op = mer_pkg::OP_SWITCH;
      mer_pkg::ST_TEST: if (sts.y_neg) cmd.op = mer_pkg::OP_FINISH;
      mer_pkg::ST_MOVE: cmd.op = mer_pkg::OP_MOVE;
      mer_pkg::ST_TERM: cmd.op = mer_pkg::OP_TERM;
      mer_pkg::ST_ACC:  cmd.op = mer_pkg::OP_ACC;
      mer_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready && quad_r != mer_pkg::QUAD_LAST) cmd.op = mer_pkg::OP_LOAD_PT;
      end
      default:          cmd.op = mer_pkg::OP_NOP;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and result channels active together");

  a_first_point: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mer_pkg::ST_ACC |=> out_valid && quad_r == mer_pkg::QUAD_FIRST)
    else $error("emission did not start at the first quadrant");

  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && quad_r == mer_pkg::QUAD_LAST |=> in_ready)
    else $error("not ready after the fourth point");

endmodule

@@ sv/mer_datapath.sv @@
// Walk state, shared multiplier and point generation of the ellipse rasterizer.
`timescale 1ns / 1ps
module mer_datapath #(
  parameter int COORD_BITS = 12
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [mer_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [mer_pkg::CFG_W-1:0]              cfg_data,
  input  logic                                   in_restart,
  input  mer_pkg::dp_cmd_t                       cmd,
  output mer_pkg::dp_sts_t                       sts,
  output logic signed [mer_pkg::OUT_W-1:0]       out_point_x,
  output logic signed [mer_pkg::OUT_W-1:0]       out_point_y,
  output logic                                   out_last_of_step,
  output logic                                   out_walk_done
);

  localparam int MASK_BITS = (COORD_BITS < mer_pkg::CENTER_W) ? COORD_BITS : mer_pkg::CENTER_W;
  localparam logic [mer_pkg::CENTER_W-1:0] CMASK =
    mer_pkg::CENTER_W'((64'd1 << MASK_BITS) - 64'd1);
  localparam int WZ = mer_pkg::WIDE_W - mer_pkg::SQ_W;

  logic [mer_pkg::CENTER_W-1:0] center_x_r, center_y_r;
  logic [mer_pkg::RADIUS_W-1:0] radius_x_r, radius_y_r;

  logic                                restart_r;
  logic [mer_pkg::SQ_W-1:0]            rx2_r, ry2_r;
  logic [mer_pkg::MUL_W-1:0]           tsqx_r, tsqy_r;
  logic [mer_pkg::PROD_W-1:0]          mul_p_r;
  logic signed [mer_pkg::ACC_W-1:0]    acc_r;
  logic [mer_pkg::POS_X_W-1:0]         pos_x_r;
  logic signed [mer_pkg::POS_Y_W-1:0]  pos_y_r;
  logic signed [mer_pkg::WIDE_W-1:0]   slope_x_r, slope_y_r, dec_r, term_r;
  logic                                region2_r, finished_r;
  logic                                use_x_r, use_y_r, use_rx_r;
  logic [mer_pkg::POS_X_W-1:0]         ux_r;
  logic [mer_pkg::POS_Y_W-2:0]         uy_r;
  logic signed [mer_pkg::OUT_W-1:0]    pt_x_r, pt_y_r;
  logic                                last_r, done_r;

  logic [mer_pkg::MUL_W-1:0]           mul_a, mul_b;
  logic [mer_pkg::POS_Y_W:0]           ty;
  logic [mer_pkg::POS_Y_W:0]           ty_abs;
  logic signed [mer_pkg::WIDE_W-1:0]   rx2_w, ry2_w, two_rx2, two_ry2, p_w;
  logic signed [mer_pkg::ACC_W-1:0]    p4, acc_diff;
  logic                                dec_neg, dec_pos;
  logic [mer_pkg::CENTER_W-1:0]        cx, cy;
  logic [mer_pkg::OUT_W-1:0]           x_plus, x_minus, y_plus, y_minus;

  assign rx2_w    = {{WZ{1'b0}}, rx2_r};
  assign ry2_w    = {{WZ{1'b0}}, ry2_r};
  assign two_rx2  = rx2_w <<< 1;
  assign two_ry2  = ry2_w <<< 1;
  assign p_w      = mul_p_r[mer_pkg::WIDE_W-1:0];
  assign p4       = {mul_p_r, 2'b00};
  assign acc_diff = acc_r - p4;
  assign dec_neg  = dec_r[mer_pkg::WIDE_W-1];
  assign dec_pos  = !dec_neg && (dec_r != '0);
  assign ty       = {pos_y_r[mer_pkg::POS_Y_W-1], pos_y_r} - 1'b1;
  assign ty_abs   = ty[mer_pkg::POS_Y_W] ? (~ty + 1'b1) : ty;
  assign cx       = center_x_r & CMASK;
  assign cy       = center_y_r & CMASK;
  assign x_plus   = mer_pkg::OUT_W'(cx) + mer_pkg::OUT_W'(ux_r);
  assign x_minus  = mer_pkg::OUT_W'(cx) - mer_pkg::OUT_W'(ux_r);
  assign y_plus   = mer_pkg::OUT_W'(cy) + mer_pkg::OUT_W'(uy_r);
  assign y_minus  = mer_pkg::OUT_W'(cy) - mer_pkg::OUT_W'(uy_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      mer_pkg::OP_SQ_RX: begin
        mul_a = mer_pkg::MUL_W'(radius_x_r);
        mul_b = mer_pkg::MUL_W'(radius_x_r);
      end
      mer_pkg::OP_SQ_RY: begin
        mul_a = mer_pkg::MUL_W'(radius_y_r);
        mul_b = mer_pkg::MUL_W'(radius_y_r);
      end
      mer_pkg::OP_RX2_RY: begin
        mul_a = mer_pkg::MUL_W'(rx2_r);
        mul_b = mer_pkg::MUL_W'(radius_y_r);
      end
      mer_pkg::OP_SQ_TX: begin
        mul_a = mer_pkg::MUL_W'({pos_x_r, 1'b1});
        mul_b = mer_pkg::MUL_W'({pos_x_r, 1'b1});
      end
      mer_pkg::OP_SQ_TY: begin
        mul_a = mer_pkg::MUL_W'(ty_abs);
        mul_b = mer_pkg::MUL_W'(ty_abs);
      end
      mer_pkg::OP_MUL_A: begin
        mul_a = mer_pkg::MUL_W'(ry2_r);
        mul_b = tsqx_r;
      end
      mer_pkg::OP_MUL_B: begin
        mul_a = mer_pkg::MUL_W'(rx2_r);
        mul_b = tsqy_r;
      end
      mer_pkg::OP_MUL_C: begin
        mul_a = mer_pkg::MUL_W'(rx2_r);
        mul_b = mer_pkg::MUL_W'(ry2_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      radius_x_r <= '0;
      radius_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mer_pkg::CFG_CENTER_X: center_x_r <= cfg_data[mer_pkg::CENTER_W-1:0];
        mer_pkg::CFG_CENTER_Y: center_y_r <= cfg_data[mer_pkg::CENTER_W-1:0];
        mer_pkg::CFG_RADIUS_X: radius_x_r <= cfg_data[mer_pkg::RADIUS_W-1:0];
        mer_pkg::CFG_RADIUS_Y: radius_y_r <= cfg_data[mer_pkg::RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region2_r  <= 1'b0;
      finished_r <= 1'b1;
    end else begin
      case (cmd.op)
        mer_pkg::OP_INIT: begin
          if (restart_r) begin
            region2_r  <= 1'b0;
            finished_r <= 1'b0;
          end
        end
        mer_pkg::OP_SWITCH: region2_r  <= 1'b1;
        mer_pkg::OP_FINISH: finished_r <= 1'b1;
        mer_pkg::OP_TERM: begin
          if (pos_y_r[mer_pkg::POS_Y_W-1]) finished_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mul_p_r <= mer_pkg::PROD_W'(mul_a) * mer_pkg::PROD_W'(mul_b);
    case (cmd.op)
      mer_pkg::OP_TAKE:   restart_r <= in_restart;
      mer_pkg::OP_SQ_RY:  rx2_r <= mul_p_r[mer_pkg::SQ_W-1:0];
      mer_pkg::OP_RX2_RY: ry2_r <= mul_p_r[mer_pkg::SQ_W-1:0];
      mer_pkg::OP_INIT: begin
        if (restart_r) begin
          pos_x_r   <= '0;
          pos_y_r   <= mer_pkg::POS_Y_W'(radius_y_r);
          slope_x_r <= '0;
          slope_y_r <= p_w <<< 1;
          dec_r     <= (ry2_w <<< 2) - (p_w <<< 2) + rx2_w;
        end
      end
      mer_pkg::OP_SQ_TY:  tsqx_r <= mul_p_r[mer_pkg::MUL_W-1:0];
      mer_pkg::OP_MUL_A:  tsqy_r <= mul_p_r[mer_pkg::MUL_W-1:0];
      mer_pkg::OP_MUL_B:  acc_r  <= {2'b00, mul_p_r};
      mer_pkg::OP_MUL_C:  acc_r  <= acc_r + p4;
      mer_pkg::OP_SWITCH: dec_r  <= acc_diff[mer_pkg::WIDE_W-1:0];
      mer_pkg::OP_MOVE: begin
        ux_r <= pos_x_r;
        uy_r <= pos_y_r[mer_pkg::POS_Y_W-2:0];
        if (!region2_r) begin
          pos_x_r   <= pos_x_r + 1'b1;
          slope_x_r <= slope_x_r + two_ry2;
          use_x_r   <= 1'b1;
          use_rx_r  <= 1'b0;
          if (dec_neg) begin
            use_y_r <= 1'b0;
          end else begin
            pos_y_r   <= pos_y_r - 1'b1;
            slope_y_r <= slope_y_r - two_rx2;
            use_y_r   <= 1'b1;
          end
        end else begin
          pos_y_r   <= pos_y_r - 1'b1;
          slope_y_r <= slope_y_r - two_rx2;
          use_y_r   <= 1'b1;
          use_rx_r  <= 1'b1;
          if (dec_pos) begin
            use_x_r <= 1'b0;
          end else begin
            pos_x_r   <= pos_x_r + 1'b1;
            slope_x_r <= slope_x_r + two_ry2;
            use_x_r   <= 1'b1;
          end
        end
      end
      mer_pkg::OP_TERM: begin
        term_r <= (use_x_r ? slope_x_r : '0) - (use_y_r ? slope_y_r : '0) +
                  (use_rx_r ? rx2_w : ry2_w);
        done_r <= pos_y_r[mer_pkg::POS_Y_W-1];
      end
      mer_pkg::OP_ACC: begin
        dec_r  <= dec_r + (term_r <<< 2);
        pt_x_r <= cmd.quad[0] ? x_minus : x_plus;
        pt_y_r <= cmd.quad[1] ? y_minus : y_plus;
        last_r <= (cmd.quad == mer_pkg::QUAD_LAST);
      end
      mer_pkg::OP_LOAD_PT: begin
        pt_x_r <= cmd.quad[0] ? x_minus : x_plus;
        pt_y_r <= cmd.quad[1] ? y_minus : y_plus;
        last_r <= (cmd.quad == mer_pkg::QUAD_LAST);
      end
      default: ;
    endcase
  end

  assign sts.finished   = finished_r;
  assign sts.switch_req = !region2_r && (slope_x_r >= slope_y_r);
  assign sts.y_neg      = pos_y_r[mer_pkg::POS_Y_W-1];

  assign out_point_x      = pt_x_r;
  assign out_point_y      = pt_y_r;
  assign out_last_of_step = last_r;
  assign out_walk_done    = done_r;

  a_finish_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(finished_r) |-> $past(cmd.op) == mer_pkg::OP_TERM ||
                          $past(cmd.op) == mer_pkg::OP_FINISH)
    else $error("walk finished outside the end test");

  a_move_live: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == mer_pkg::OP_MOVE |-> !finished_r && !pos_y_r[mer_pkg::POS_Y_W-1])
    else $error("iteration advanced on a finished walk");

  a_switch_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == mer_pkg::OP_SWITCH |-> !region2_r)
    else $error("region switch requested while already in region two");

endmodule

@@ sv/midpoint_ellipse_rasterizer_unit.sv @@
// Top level of the midpoint ellipse rasterizer.
`timescale 1ns / 1ps
// Usage:
//   Write center_x, center_y, radius_x, radius_y through cfg_we/cfg_index/cfg_data
//   (indexes 0..3) while no transaction is in flight. Each input transaction
//   carries in_restart: 1 starts a new walk at the top of the ellipse, 0 advances
//   the current walk by one iteration. A live step returns four result
//   transactions, points (+x,+y), (-x,+y), (+x,-y), (-x,-y) around the center;
//   out_last_of_step marks the fourth and out_walk_done marks the final position.
//   A finished walk returns nothing until restarted.
// Timing:
//   One transaction at a time. A step that emits runs the multiplier sequencing
//   and update after input acceptance, then offers one point per cycle when the
//   receiver never stalls; the next input transaction is taken after the fourth
//   point. The step that enters the second region first reloads the decision,
//   which runs through the single shared 26x26 multiplier. A step that emits
//   nothing raises in_ready again without any result transaction.
//   A receiver stall holds the current point; in_ready stays low until the
//   fourth point is taken.
// Reset:
//   Synchronous, active low: configuration cleared, no walk active.
module midpoint_ellipse_rasterizer_unit #(
  parameter int COORD_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_restart,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [mer_pkg::OUT_W-1:0]   out_point_x,
  output logic signed [mer_pkg::OUT_W-1:0]   out_point_y,
  output logic                               out_last_of_step,
  output logic                               out_walk_done,
  input  logic                               cfg_we,
  input  logic [mer_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mer_pkg::CFG_W-1:0]          cfg_data
);

  mer_pkg::dp_cmd_t cmd;
  mer_pkg::dp_sts_t sts;

  mer_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mer_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_restart       (in_restart),
    .cmd              (cmd),
    .sts              (sts),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_last_of_step (out_last_of_step),
    .out_walk_done    (out_walk_done)
  );

endmodule
